FILE: hdl/urie_pkg.sv
// Shared types, constants and the character map for the request ID encoder.
// No dependencies; every other file imports this package.
`default_nettype none
package urie_pkg;

  localparam int RECORD_BYTES = 20;
  localparam int ID_CHARS     = 27;
  localparam int ROOT_BYTES   = 10;
  localparam int RECORD_BITS  = RECORD_BYTES * 8;

  localparam int SEXTET_W = 6;
  localparam int CHAR_W   = 7;
  localparam int POS_W    = 5;

  localparam int STAMP_W = 32;
  localparam int CONN_W  = 32;
  localparam int CTR_W   = 32;
  localparam int CNT16_W = 16;
  localparam int ROOT_UPPER_W = 16;
  localparam int ROOT_LOWER_W = 64;

  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 5;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CNT16_W-1:0] CNT16_MAX = 16'hffff;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;
  localparam logic [CHAR_W-1:0] CHAR_UNDER = 7'h5f;

  typedef enum logic [1:0] {
    REG_ROOT_UPPER    = 2'd0,
    REG_ROOT_LOWER    = 2'd1,
    REG_COUNTER_START = 2'd2
  } reg_idx_t;

  // Field order gives the big-endian record, first byte in the top bits.
  typedef struct packed {
    logic [STAMP_W-1:0]        stamp;
    logic [ROOT_BYTES*8-1:0]   root;
    logic [CNT16_W-1:0]        cnt;
    logic [CONN_W-1:0]         conn;
  } id_rec_t;

  // Counter load request from the register block.
  typedef struct packed {
    logic             load;
    logic [CTR_W-1:0] value;
  } ctr_load_t;

  function automatic logic [CHAR_W-1:0] sextet_to_char(input logic [SEXTET_W-1:0] v);
    logic [CHAR_W-1:0] w;
    w = {1'b0, v};
    if (v < 6'd26) begin
      return w + 7'd65;
    end else if (v < 6'd52) begin
      return w + 7'd71;
    end else if (v < 6'd62) begin
      return w - 7'd4;
    end else if (v == 6'd62) begin
      return CHAR_MINUS;
    end
    return CHAR_UNDER;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/urie_front.sv
// Front end: takes request transactions, holds the running request counter
// and packs the 20-byte record. Depends on urie_pkg.
`default_nettype none
module urie_front (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_push,
  input  wire logic [urie_pkg::STAMP_W-1:0]          in_request_seconds,
  input  wire logic [urie_pkg::CONN_W-1:0]           in_connection_index,
  input  wire logic                                  q_full,
  input  wire logic [urie_pkg::ROOT_UPPER_W-1:0]     root_upper,
  input  wire logic [urie_pkg::ROOT_LOWER_W-1:0]     root_lower,
  input  wire urie_pkg::ctr_load_t                   ctr_load,
  output logic                                       q_push,
  output urie_pkg::id_rec_t                          q_data
);
  import urie_pkg::*;

  logic [CTR_W-1:0]   counter_r, counter_nxt;
  logic [CNT16_W:0]   fold_sum;
  logic [CNT16_W-1:0] fold_one;
  logic [CNT16_W-1:0] cnt16;

  assign q_push = in_push && !q_full;

  // 2^16 is 1 modulo 65535, so the high and low halves fold together.
  assign fold_sum = {1'b0, counter_r[CTR_W-1:CNT16_W]} + {1'b0, counter_r[CNT16_W-1:0]};
  assign fold_one = fold_sum[CNT16_W-1:0] + {{(CNT16_W-1){1'b0}}, fold_sum[CNT16_W]};
  assign cnt16    = (fold_one == CNT16_MAX) ? '0 : fold_one;

  always_comb begin
    q_data.stamp = in_request_seconds;
    q_data.root  = {root_upper, root_lower};
    q_data.cnt   = cnt16;
    q_data.conn  = in_connection_index;
  end

  always_comb begin
    counter_nxt = counter_r;
    if (ctr_load.load) begin
      counter_nxt = ctr_load.value;
    end else if (q_push) begin
      counter_nxt = counter_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      counter_r <= '0;
    end else begin
      counter_r <= counter_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/urie_queue.sv
// Short record queue between the front end and the character serializer.
// Depends on urie_pkg for the record type and depth.
`default_nettype none
module urie_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire urie_pkg::id_rec_t    push_data,
  output logic                      full,
  input  wire logic                 pop,
  output logic                      valid,
  output urie_pkg::id_rec_t         head
);
  import urie_pkg::*;

  id_rec_t           entries_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign full    = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign valid   = (count_r != '0);
  assign head    = entries_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/urie_back.sv
// Back end: shifts a record out six bits at a time and maps each sextet to
// a base64url character in an output register. Depends on urie_pkg.
`default_nettype none
module urie_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        q_valid,
  input  wire urie_pkg::id_rec_t           q_head,
  output logic                             q_pop,
  output logic                             out_empty,
  input  wire logic                        out_pop,
  output logic [urie_pkg::CHAR_W-1:0]      out_id_char,
  output logic                             out_last_char
);
  import urie_pkg::*;

  logic [RECORD_BITS-1:0] sh_r, sh_nxt;
  logic [POS_W-1:0]       pos_r, pos_nxt;
  logic                   busy_r, busy_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]      out_char_r, out_char_nxt;
  logic                   out_last_r, out_last_nxt;
  logic                   adv, at_last, load;

  assign adv     = !out_valid_r || out_pop;
  assign at_last = (pos_r == POS_W'(ID_CHARS - 1));
  // A record is taken when idle, or in the cycle the last character moves to the output register.
  assign load    = q_valid && (!busy_r || (adv && at_last));
  assign q_pop   = load;

  assign out_empty     = !out_valid_r;
  assign out_id_char   = out_char_r;
  assign out_last_char = out_last_r;

  always_comb begin
    sh_nxt        = sh_r;
    pos_nxt       = pos_r;
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    if (adv) begin
      out_valid_nxt = busy_r;
      if (busy_r) begin
        out_char_nxt = sextet_to_char(sh_r[RECORD_BITS-1 -: SEXTET_W]);
        out_last_nxt = at_last;
        // Zeros shift in, which gives the padding bits of the final character.
        sh_nxt       = sh_r << SEXTET_W;
        if (at_last) begin
          busy_nxt = 1'b0;
          pos_nxt  = '0;
        end else begin
          pos_nxt = pos_r + 1'b1;
        end
      end
    end
    if (load) begin
      sh_nxt   = q_head;
      pos_nxt  = '0;
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    sh_r       <= sh_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/unique_request_id_encoder_core.sv
// Request ID encoder: each request yields 27 base64url characters.
// A request goes through the queue, the shift register and the output register.
// One character per cycle leaves the output register while out_pop takes each one.
// Two records queue between front and back, so requests are taken while one is sent.
// Synchronous active-low reset clears the counter, registers, queue and output.
`default_nettype none
module unique_request_id_encoder_core (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_push,
  output logic                                       in_full,
  input  wire logic [urie_pkg::STAMP_W-1:0]          in_request_seconds,
  input  wire logic [urie_pkg::CONN_W-1:0]           in_connection_index,
  output logic                                       out_empty,
  input  wire logic                                  out_pop,
  output logic [urie_pkg::CHAR_W-1:0]                out_id_char,
  output logic                                       out_last_char,
  input  wire logic                                  cfg_psel,
  input  wire logic                                  cfg_penable,
  input  wire logic                                  cfg_pwrite,
  input  wire logic [urie_pkg::CFG_ADDR_W-1:0]       cfg_paddr,
  input  wire logic [urie_pkg::CFG_DATA_W-1:0]       cfg_pwdata,
  output logic [urie_pkg::CFG_DATA_W-1:0]            cfg_prdata,
  output logic                                       cfg_pready
);
  import urie_pkg::*;

  logic [ROOT_UPPER_W-1:0] root_upper_r;
  logic [ROOT_LOWER_W-1:0] root_lower_r;
  logic [CTR_W-1:0]        counter_start_r;
  logic [1:0]              reg_sel;
  logic                    wr_en;
  ctr_load_t               ctr_load;
  logic                    q_push, q_full, q_valid, q_pop;
  id_rec_t                 q_in, q_head;

  assign cfg_pready = 1'b1;
  assign reg_sel    = cfg_paddr[4:3];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    ctr_load.load  = wr_en && (reg_sel == REG_COUNTER_START);
    ctr_load.value = cfg_pwdata[CTR_W-1:0];
  end

  always_comb begin
    case (reg_sel)
      REG_ROOT_UPPER:    cfg_prdata = {{(CFG_DATA_W-ROOT_UPPER_W){1'b0}}, root_upper_r};
      REG_ROOT_LOWER:    cfg_prdata = root_lower_r;
      REG_COUNTER_START: cfg_prdata = {{(CFG_DATA_W-CTR_W){1'b0}}, counter_start_r};
      default:           cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_upper_r    <= '0;
      root_lower_r    <= '0;
      counter_start_r <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_ROOT_UPPER:    root_upper_r    <= cfg_pwdata[ROOT_UPPER_W-1:0];
        REG_ROOT_LOWER:    root_lower_r    <= cfg_pwdata;
        REG_COUNTER_START: counter_start_r <= cfg_pwdata[CTR_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_full = q_full;

  urie_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_push             (in_push),
    .in_request_seconds  (in_request_seconds),
    .in_connection_index (in_connection_index),
    .q_full              (q_full),
    .root_upper          (root_upper_r),
    .root_lower          (root_lower_r),
    .ctr_load            (ctr_load),
    .q_push              (q_push),
    .q_data              (q_in)
  );

  urie_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  urie_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_id_char   (out_id_char),
    .out_last_char (out_last_char)
  );

endmodule
`default_nettype wire
